FILE: sv/flv_dmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_dmx_pkg
// Shared constants for the FLV stream demuxer: phase codes, byte roles,
// error codes, tag types and section lengths.
// ----------------------------------------------------------------------------
package flv_dmx_pkg;

   // parse phase codes
   localparam logic [2:0] PH_HDR  = 3'd0;
   localparam logic [2:0] PH_PREV = 3'd1;
   localparam logic [2:0] PH_TAG  = 3'd2;
   localparam logic [2:0] PH_SUB  = 3'd3;
   localparam logic [2:0] PH_PAY  = 3'd4;
   localparam logic [2:0] PH_ERR  = 3'd5;

   // byte roles on the result channel
   localparam logic [2:0] ROLE_FILE_HDR = 3'd0;
   localparam logic [2:0] ROLE_PREV     = 3'd1;
   localparam logic [2:0] ROLE_TAG_HDR  = 3'd2;
   localparam logic [2:0] ROLE_SUB_HDR  = 3'd3;
   localparam logic [2:0] ROLE_PAYLOAD  = 3'd4;
   localparam logic [2:0] ROLE_IGNORED  = 3'd5;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_SIGNATURE = 3'd1;
   localparam logic [2:0] ERR_NO_MEDIA  = 3'd2;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd3;
   localparam logic [2:0] ERR_ENCRYPTED = 3'd4;
   localparam logic [2:0] ERR_TOO_SHORT = 3'd5;

   // signature
   localparam logic [7:0] SIG_F = 8'h46;
   localparam logic [7:0] SIG_L = 8'h4C;
   localparam logic [7:0] SIG_V = 8'h56;

   // tag types and codec
   localparam logic [4:0] KIND_AUDIO = 5'd8;
   localparam logic [4:0] KIND_VIDEO = 5'd9;
   localparam logic [4:0] KIND_META  = 5'd18;
   localparam logic [3:0] CODEC_AVC  = 4'd7;

   // section lengths
   localparam int FILE_HDR_LEN = 9;
   localparam int TAG_HDR_LEN  = 11;
   localparam int PREV_LEN     = 4;
   localparam int AVC_SUB_LEN  = 5;

   // byte index within the file header holding the media flags
   localparam logic [3:0] HDR_FLAGS_IDX = 4'd4;

endpackage

FILE: sv/flv_stream_demuxer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_stream_demuxer
// Byte-wide FLV demultiplexer: header check, tag header decode, media
// sub-header decode and payload pass-through with a sticky error state.
// ----------------------------------------------------------------------------
// One word in gives one word out. For each accepted byte, the parse state
// (phase, byte counter, payload countdown and the current tag's fields) is
// updated by one layer of compares and shifts, and the result lands in an
// output register. A new byte is accepted in every cycle while the output
// register is empty or being drained in that same cycle, so the sustained
// rate is one byte per clock; the only stall comes from the result side
// holding rsp_ready low. After an error every further byte is reported
// with the ignored role until reset.
// ----------------------------------------------------------------------------
module flv_stream_demuxer (
   input  logic               clock,
   input  logic               reset,
   // input words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_byte_role,
   output logic [7:0]         rsp_payload_byte,
   output logic [4:0]         rsp_tag_kind,
   output logic [23:0]        rsp_body_size,
   output logic [31:0]        rsp_time_stamp,
   output logic [23:0]        rsp_stream_number,
   output logic [7:0]         rsp_media_flags,
   output logic [7:0]         rsp_avc_kind,
   output logic signed [23:0] rsp_composition_offset,
   output logic               rsp_tag_end,
   output logic [2:0]         rsp_error_code,
   output logic [1:0]         rsp_stream_flags
);

   // last-byte indices or lengths of the sections, as counter values
   localparam logic [3:0] HDR_LAST  = 4'(flv_dmx_pkg::FILE_HDR_LEN - 1);
   localparam logic [3:0] TAG_LAST  = 4'(flv_dmx_pkg::TAG_HDR_LEN - 1);
   localparam logic [3:0] PREV_CNT  = 4'(flv_dmx_pkg::PREV_LEN);
   localparam logic [3:0] AVC_LAST  = 4'(flv_dmx_pkg::AVC_SUB_LEN - 1);
   localparam logic [23:0] AVC_LEN  = 24'(flv_dmx_pkg::AVC_SUB_LEN);

   // parse state
   logic [2:0]  phase_ff,   phase_in;
   logic [3:0]  cnt_ff,     cnt_in;
   logic [23:0] left_ff,    left_in;
   logic [4:0]  kind_ff,    kind_in;
   logic        enc_ff,     enc_in;
   logic [23:0] size_ff,    size_in;
   logic [31:0] time_ff,    time_in;
   logic [23:0] stream_ff,  stream_in;
   logic [7:0]  media_ff,   media_in;
   logic [7:0]  avck_ff,    avck_in;
   logic [23:0] comp_ff,    comp_in;
   logic [2:0]  err_ff,     err_in;
   logic [1:0]  flags_ff,   flags_in;

   // output register
   logic        rsp_valid_ff;
   logic [2:0]  role_ff;
   logic [7:0]  byte_ff;
   logic        end_ff;

   logic        accept;
   logic [7:0]  b;
   logic [3:0]  cnt_inc;
   logic [2:0]  role;
   logic        tag_end;
   logic        bad_sig;
   logic        known_kind;
   logic        avc_video;
   logic [23:0] left_after_one;
   logic [23:0] left_after_avc;
   logic [23:0] left_dec;

   // skid-free output stage: refill when empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_data_byte;
   assign cnt_inc   = cnt_ff + 4'd1;

   assign left_after_one = size_ff - 24'd1;
   assign left_after_avc = size_ff - AVC_LEN;
   assign left_dec       = left_ff - 24'd1;

   // signature byte mismatch on one of the first three header bytes
   assign bad_sig = (cnt_ff == 4'd0 && b != flv_dmx_pkg::SIG_F) ||
                    (cnt_ff == 4'd1 && b != flv_dmx_pkg::SIG_L) ||
                    (cnt_ff == 4'd2 && b != flv_dmx_pkg::SIG_V);

   // type byte was latched on the first tag header byte
   assign known_kind = (kind_ff == flv_dmx_pkg::KIND_AUDIO) ||
                       (kind_ff == flv_dmx_pkg::KIND_VIDEO) ||
                       (kind_ff == flv_dmx_pkg::KIND_META);

   assign avc_video = (kind_ff == flv_dmx_pkg::KIND_VIDEO) &&
                      (b[3:0] == flv_dmx_pkg::CODEC_AVC);

   // ---------------------------------------------------------------------
   // next-state logic for one byte
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;
      kind_in   = kind_ff;
      enc_in    = enc_ff;
      size_in   = size_ff;
      time_in   = time_ff;
      stream_in = stream_ff;
      media_in  = media_ff;
      avck_in   = avck_ff;
      comp_in   = comp_ff;
      err_in    = err_ff;
      flags_in  = flags_ff;
      tag_end   = 1'b0;
      role      = flv_dmx_pkg::ROLE_IGNORED;

      unique case (phase_ff)
         flv_dmx_pkg::PH_HDR: begin
            role   = flv_dmx_pkg::ROLE_FILE_HDR;
            cnt_in = cnt_inc;
            if (bad_sig) begin
               err_in   = flv_dmx_pkg::ERR_SIGNATURE;
               phase_in = flv_dmx_pkg::PH_ERR;
               cnt_in   = 4'd0;
            end else if (cnt_ff == flv_dmx_pkg::HDR_FLAGS_IDX) begin
               // audio flag is bit 2, video flag bit 0
               flags_in = {b[2], b[0]};
               if (!(b[2] || b[0])) begin
                  err_in   = flv_dmx_pkg::ERR_NO_MEDIA;
                  phase_in = flv_dmx_pkg::PH_ERR;
                  cnt_in   = 4'd0;
               end
            end else if (cnt_ff >= HDR_LAST) begin
               phase_in = flv_dmx_pkg::PH_PREV;
               cnt_in   = 4'd0;
            end
         end

         flv_dmx_pkg::PH_PREV: begin
            role   = flv_dmx_pkg::ROLE_PREV;
            cnt_in = cnt_inc;
            if (cnt_inc >= PREV_CNT) begin
               phase_in = flv_dmx_pkg::PH_TAG;
               cnt_in   = 4'd0;
            end
         end

         flv_dmx_pkg::PH_TAG: begin
            role   = flv_dmx_pkg::ROLE_TAG_HDR;
            cnt_in = cnt_inc;
            // field capture, big-endian shift-in
            priority if (cnt_ff == 4'd0) begin
               enc_in    = b[5];
               kind_in   = b[4:0];
               size_in   = '0;
               time_in   = '0;
               stream_in = '0;
               media_in  = '0;
               avck_in   = '0;
               comp_in   = '0;
            end else if (cnt_ff <= 4'd3) begin
               size_in = {size_ff[15:0], b};
            end else if (cnt_ff <= 4'd6) begin
               time_in = {time_ff[31:24], time_ff[15:0], b};
            end else if (cnt_ff == 4'd7) begin
               time_in = {b, time_ff[23:0]};
            end else begin
               stream_in = {stream_ff[15:0], b};
            end
            // checks on the last tag header byte
            if (cnt_ff >= TAG_LAST) begin
               cnt_in = 4'd0;
               priority if (!known_kind) begin
                  err_in   = flv_dmx_pkg::ERR_BAD_TYPE;
                  phase_in = flv_dmx_pkg::PH_ERR;
               end else if (kind_in == flv_dmx_pkg::KIND_META) begin
                  priority if (enc_in) begin
                     err_in   = flv_dmx_pkg::ERR_ENCRYPTED;
                     phase_in = flv_dmx_pkg::PH_ERR;
                  end else if (size_in == 24'd0) begin
                     phase_in = flv_dmx_pkg::PH_PREV;
                     tag_end  = 1'b1;
                  end else begin
                     left_in  = size_in;
                     phase_in = flv_dmx_pkg::PH_PAY;
                  end
               end else if (size_in == 24'd0) begin
                  err_in   = flv_dmx_pkg::ERR_TOO_SHORT;
                  phase_in = flv_dmx_pkg::PH_ERR;
               end else begin
                  phase_in = flv_dmx_pkg::PH_SUB;
               end
            end
         end

         flv_dmx_pkg::PH_SUB: begin
            role   = flv_dmx_pkg::ROLE_SUB_HDR;
            cnt_in = cnt_inc;
            priority if (cnt_ff == 4'd0) begin
               media_in = b;
               priority if (avc_video) begin
                  if (size_ff < AVC_LEN) begin
                     err_in   = flv_dmx_pkg::ERR_TOO_SHORT;
                     phase_in = flv_dmx_pkg::PH_ERR;
                     cnt_in   = 4'd0;
                  end
               end else if (enc_ff) begin
                  err_in   = flv_dmx_pkg::ERR_ENCRYPTED;
                  phase_in = flv_dmx_pkg::PH_ERR;
                  cnt_in   = 4'd0;
               end else begin
                  // one-byte sub-header done
                  cnt_in  = 4'd0;
                  left_in = left_after_one;
                  if (left_after_one == 24'd0) begin
                     phase_in = flv_dmx_pkg::PH_PREV;
                     tag_end  = 1'b1;
                  end else begin
                     phase_in = flv_dmx_pkg::PH_PAY;
                  end
               end
            end else if (cnt_ff == 4'd1) begin
               avck_in = b;
            end else begin
               comp_in = {comp_ff[15:0], b};
               if (cnt_ff >= AVC_LAST) begin
                  cnt_in = 4'd0;
                  if (enc_ff) begin
                     err_in   = flv_dmx_pkg::ERR_ENCRYPTED;
                     phase_in = flv_dmx_pkg::PH_ERR;
                  end else begin
                     left_in = left_after_avc;
                     if (left_after_avc == 24'd0) begin
                        phase_in = flv_dmx_pkg::PH_PREV;
                        tag_end  = 1'b1;
                     end else begin
                        phase_in = flv_dmx_pkg::PH_PAY;
                     end
                  end
               end
            end
         end

         flv_dmx_pkg::PH_PAY: begin
            role    = flv_dmx_pkg::ROLE_PAYLOAD;
            left_in = left_dec;
            if (left_dec == 24'd0) begin
               phase_in = flv_dmx_pkg::PH_PREV;
               cnt_in   = 4'd0;
               tag_end  = 1'b1;
            end
         end

         default: begin
            // sticky error: everything holds
            role = flv_dmx_pkg::ROLE_IGNORED;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // parse state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= flv_dmx_pkg::PH_HDR;
         cnt_ff    <= '0;
         left_ff   <= '0;
         kind_ff   <= '0;
         enc_ff    <= 1'b0;
         size_ff   <= '0;
         time_ff   <= '0;
         stream_ff <= '0;
         media_ff  <= '0;
         avck_ff   <= '0;
         comp_ff   <= '0;
         err_ff    <= flv_dmx_pkg::ERR_NONE;
         flags_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         left_ff   <= left_in;
         kind_ff   <= kind_in;
         enc_ff    <= enc_in;
         size_ff   <= size_in;
         time_ff   <= time_in;
         stream_ff <= stream_in;
         media_ff  <= media_in;
         avck_ff   <= avck_in;
         comp_ff   <= comp_in;
         err_ff    <= err_in;
         flags_ff  <= flags_in;
      end
   end

   // ---------------------------------------------------------------------
   // result word register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         role_ff <= role;
         byte_ff <= b;
         end_ff  <= tag_end;
      end
   end

   // tag fields show the state after the byte, so they come from the
   // state registers, which load in step with the result word
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_byte_role          = role_ff;
   assign rsp_payload_byte       = byte_ff;
   assign rsp_tag_kind           = kind_ff;
   assign rsp_body_size          = size_ff;
   assign rsp_time_stamp         = time_ff;
   assign rsp_stream_number      = stream_ff;
   assign rsp_media_flags        = media_ff;
   assign rsp_avc_kind           = avck_ff;
   assign rsp_composition_offset = signed'(comp_ff);
   assign rsp_tag_end            = end_ff;
   assign rsp_error_code         = err_ff;
   assign rsp_stream_flags       = flags_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // error state is left only by reset
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == flv_dmx_pkg::PH_ERR |=> phase_ff == flv_dmx_pkg::PH_ERR)
      else $error("error phase left without reset");

   // error code set exactly when parked in the error phase
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      (err_ff != flv_dmx_pkg::ERR_NONE) == (phase_ff == flv_dmx_pkg::PH_ERR))
      else $error("error code and phase disagree");

   // a tag never ends on an erroring or ignored word
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tag_end |->
         rsp_error_code == flv_dmx_pkg::ERR_NONE &&
         rsp_byte_role != flv_dmx_pkg::ROLE_IGNORED)
      else $error("tag end flagged with error");

   // payload phase always has bytes left
   a_pay_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == flv_dmx_pkg::PH_PAY |-> left_ff != 24'd0)
      else $error("payload phase with empty countdown");

endmodule
